FILE: rtl/rcsp_pkg.sv
package rcsp_pkg;

  // Field widths
  localparam int DELTA_W    = 16;
  localparam int ANGLE_W    = 17;
  localparam int PAUSE_W    = 24;
  localparam int GAIN_W     = 16;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int MSTEP_W    = DELTA_W + GAIN_W;
  localparam int GAIN_FRAC  = 8;
  localparam int STEP_W     = MSTEP_W - GAIN_FRAC;
  localparam int F2_W       = 18;
  localparam int MANG_W     = ANGLE_W + F2_W;

  // Parameter defaults
  localparam int COS_TABLE_DEPTH_DEF    = 256;
  localparam int TIME_FRACTION_BITS_DEF = 16;

  // Register reset values
  localparam logic [ANGLE_W-1:0] MAX_ANGLE_RST = 17'd23040;
  localparam logic [PAUSE_W-1:0] PAUSE_RST     = 24'd0;
  localparam logic [GAIN_W-1:0]  GAIN_RST      = 16'd256;

  localparam logic [PAUSE_W-1:0] PAUSE_MAX = '1;

  // Cosine table construction (Q30 Taylor series, Q16 entries)
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [F2_W-1:0] F2_ONE  = 18'd65536;
  localparam logic [F2_W-1:0] F2_TWO  = 18'd131072;
  localparam logic [ANGLE_W-1:0] ROUND_HALF = 17'd65536;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_DURATION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN     = 2'd2;

  typedef enum logic [1:0] {
    PH_FORWARD  = 2'd0,
    PH_PAUSED   = 2'd1,
    PH_BACKWARD = 2'd2,
    PH_DONE     = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_STEP,
    ST_UPDATE,
    ST_ROM,
    ST_MUL_ANG,
    ST_FINISH
  } seq_state_t;

  typedef struct packed {
    logic [DELTA_W-1:0] delta_time;
    logic               restart;
  } sweep_in_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [1:0]         phase_code;
    logic               finished;
  } sweep_out_t;

endpackage

FILE: rtl/raised_cosine_sweep_profile_core.sv
// Sequencing: an accepted tick runs a bit-serial step multiply, the tick update, a table read
//   and a bit-serial angle multiply before the result; a tick that holds or enters the pause
//   at the peak, or ends the sweep, skips the table read and angle multiply, and restart and
//   done requests go straight to the result, which waits while the output is stalled.
// Throughput: one request in work at a time; the next is taken in the cycle the result shows.
// Reset: synchronous rst_n restores register defaults and the forward start at angle 0.
module raised_cosine_sweep_profile_core
  import rcsp_pkg::*;
#(
  parameter int COS_TABLE_DEPTH    = COS_TABLE_DEPTH_DEF,
  parameter int TIME_FRACTION_BITS = TIME_FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sweep_in_t             in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sweep_out_t            out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int TFB   = TIME_FRACTION_BITS;
  localparam int E_W   = TFB + 2;                         // elapsed spans [0, 4.0)
  localparam int SUM_W = ((E_W > STEP_W) ? E_W : STEP_W) + 1;
  localparam int IDX_W = $clog2(COS_TABLE_DEPTH + 1);
  localparam int IP_W  = TFB + $clog2(2 * COS_TABLE_DEPTH) + 2;
  localparam int CNT_W = $clog2(F2_W);

  localparam logic [E_W-1:0] TIME_ONE    = E_W'(1) << TFB;
  localparam logic [E_W-1:0] TIME_TWO    = E_W'(2) << TFB;
  localparam logic [E_W-1:0] ELAPSED_MAX = '1;
  localparam logic [TFB-1:0] TIME_HALF   = TFB'(1) << (TFB - 1);

  // Quarter-wave cosine entry k in Q16, built at elaboration by a Taylor series in Q30.
  function automatic logic [16:0] cos_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x    = (64'(k) * HALF_PI_Q30) / 64'(COS_TABLE_DEPTH);
    x2   = (x * x) >> 30;
    term = Q30_ONE;
    sum  = Q30_ONE;
    term = ((term * x2) >> 30) / 64'd2;   sum = sum - term;
    term = ((term * x2) >> 30) / 64'd12;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd30;  sum = sum - term;
    term = ((term * x2) >> 30) / 64'd56;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd90;  sum = sum - term;
    term = ((term * x2) >> 30) / 64'd132; sum = sum + term;
    term = ((term * x2) >> 30) / 64'd182; sum = sum - term;
    term = ((term * x2) >> 30) / 64'd240; sum = sum + term;
    term = ((term * x2) >> 30) / 64'd306; sum = sum - term;
    if (sum > (64'd1 << 62)) begin
      sum = '0;                           // wrapped below zero
    end else if (sum > Q30_ONE) begin
      sum = Q30_ONE;
    end
    return 17'((sum + (64'd1 << 13)) >> 14);
  endfunction

  // Constant cosine table
  logic [16:0] cos_rom [COS_TABLE_DEPTH + 1];
  for (genvar g = 0; g <= COS_TABLE_DEPTH; g++) begin : g_rom
    assign cos_rom[g] = cos_entry(g);
  end

  // Configuration registers
  logic [ANGLE_W-1:0] max_angle_r;
  logic [PAUSE_W-1:0] pause_dur_r;
  logic [GAIN_W-1:0]  gain_r;

  // Sweep state
  phase_t             phase_r;
  logic [E_W-1:0]     elapsed_r;
  logic [PAUSE_W-1:0] pause_el_r;
  logic [ANGLE_W-1:0] held_r;

  // Sequencer and serial datapath
  seq_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [MSTEP_W-1:0] mstep_r, mstep_nxt;
  logic [MANG_W-1:0]  mang_r, mang_nxt;
  logic [IDX_W-1:0]   idx_r;
  logic               upper_r;
  logic               invert_r;
  logic               out_valid_r;
  sweep_out_t         out_data_r;

  logic               out_load;
  logic               accept;
  logic               skip_work;
  logic               step_last;
  logic               ang_last;

  // Update-stage results
  logic [STEP_W-1:0]  step;
  logic [PAUSE_W:0]   p_sum;
  logic [PAUSE_W-1:0] p_sat;
  logic [E_W-1:0]     e_base;
  logic [SUM_W-1:0]   e_sum;
  logic [E_W-1:0]     e_sat;
  logic [E_W-1:0]     e_new;
  logic [PAUSE_W-1:0] p_new;
  phase_t             ph_new;
  logic [ANGLE_W-1:0] held_new;
  logic               need_mul;
  logic               invert_new;
  logic               active;
  logic [TFB-1:0]     u;
  logic [TFB-1:0]     v;
  logic [IP_W-1:0]    idx_prod;
  logic [IP_W-1:0]    idx_wide;
  logic [IDX_W-1:0]   idx_new;

  // Angle-stage operand
  logic [16:0]        cos_val;
  logic [F2_W-1:0]    f2_rise;
  logic [F2_W-1:0]    f2;

  assign accept    = in_valid && in_ready;
  assign skip_work = in_data.restart || (phase_r == PH_DONE);
  assign step_last = (cnt_r == CNT_W'(DELTA_W - 1));
  assign ang_last  = (cnt_r == CNT_W'(F2_W - 1));
  assign cfg_ready = 1'b1;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = skip_work ? ST_FINISH : ST_MUL_STEP;
      ST_MUL_STEP: if (step_last) state_nxt = ST_UPDATE;
      ST_UPDATE:   state_nxt = need_mul ? ST_ROM : ST_FINISH;
      ST_ROM:      state_nxt = ST_MUL_ANG;
      ST_MUL_ANG:  if (ang_last) state_nxt = ST_FINISH;
      ST_FINISH:   if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_FINISH: out_load = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // Shift-add multipliers: one multiplier bit per cycle, the product shifts in from the top.
  always_comb begin
    logic [GAIN_W:0]  s_sum;
    logic [ANGLE_W:0] a_sum;
    s_sum     = {1'b0, mstep_r[MSTEP_W-1:DELTA_W]} + (mstep_r[0] ? {1'b0, gain_r} : '0);
    mstep_nxt = {s_sum, mstep_r[DELTA_W-1:1]};
    a_sum     = {1'b0, mang_r[MANG_W-1:F2_W]} + (mang_r[0] ? {1'b0, max_angle_r} : '0);
    mang_nxt  = {a_sum, mang_r[F2_W-1:1]};
  end

  assign step = mstep_r[MSTEP_W-1:GAIN_FRAC];

  // Tick update: timers, phase transitions and the cosine index.
  always_comb begin
    p_sum      = {1'b0, pause_el_r} + (PAUSE_W + 1)'(step);
    p_sat      = (p_sum > {1'b0, PAUSE_MAX}) ? PAUSE_MAX : p_sum[PAUSE_W-1:0];
    e_new      = elapsed_r;
    p_new      = pause_el_r;
    ph_new     = phase_r;
    held_new   = held_r;
    need_mul   = 1'b0;
    invert_new = 1'b0;
    active     = 1'b1;
    e_base     = elapsed_r;

    if (phase_r == PH_PAUSED) begin
      if (p_sat >= pause_dur_r) begin
        // Drop the pause overshoot and resume the return at 1.0 within this tick.
        p_new  = '0;
        ph_new = PH_BACKWARD;
        e_base = TIME_ONE;
      end else begin
        p_new    = p_sat;
        held_new = max_angle_r;
        active   = 1'b0;
      end
    end

    e_sum = SUM_W'(e_base) + SUM_W'(step);
    e_sat = (e_sum > SUM_W'(ELAPSED_MAX)) ? ELAPSED_MAX : e_sum[E_W-1:0];

    if (active) begin
      e_new = e_sat;
      if (phase_r == PH_FORWARD) begin
        if (e_sat >= TIME_ONE) begin
          e_new = TIME_ONE;
          if (pause_dur_r != '0) begin
            ph_new   = PH_PAUSED;
            held_new = max_angle_r;
            active   = 1'b0;
          end else begin
            ph_new = PH_BACKWARD;
          end
        end else begin
          need_mul = 1'b1;
        end
      end
      if (active && ph_new == PH_BACKWARD) begin
        if (e_new >= TIME_TWO) begin
          e_new    = TIME_TWO;
          held_new = '0;
          ph_new   = PH_DONE;
        end else begin
          need_mul   = 1'b1;
          invert_new = 1'b1;
        end
      end
    end

    // Fractional position within the rise or the return; mirror the upper half.
    u        = e_new[TFB-1:0];
    v        = u[TFB-1] ? TFB'({1'b1, {TFB{1'b0}}} - {1'b0, u}) : u;
    idx_prod = IP_W'(v) * IP_W'(2 * COS_TABLE_DEPTH) + IP_W'(TIME_HALF);
    idx_wide = idx_prod >> TFB;
    idx_new  = (idx_wide > IP_W'(COS_TABLE_DEPTH)) ? IDX_W'(COS_TABLE_DEPTH)
                                                    : idx_wide[IDX_W-1:0];
  end

  // Twice the rise factor in Q16 (the rise factor in Q17), flipped for the return.
  always_comb begin
    cos_val = cos_rom[idx_r];
    f2_rise = upper_r ? (F2_ONE + F2_W'(cos_val)) : (F2_ONE - F2_W'(cos_val));
    f2      = invert_r ? (F2_TWO - f2_rise) : f2_rise;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_angle_r <= MAX_ANGLE_RST;
      pause_dur_r <= PAUSE_RST;
      gain_r      <= GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_ANGLE:      max_angle_r <= cfg_data[ANGLE_W-1:0];
        CFG_PAUSE_DURATION: pause_dur_r <= cfg_data[PAUSE_W-1:0];
        CFG_SPEED_GAIN:     gain_r      <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sweep state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_FORWARD;
      elapsed_r  <= '0;
      pause_el_r <= '0;
      held_r     <= '0;
    end else begin
      if (accept && in_data.restart) begin
        phase_r    <= PH_FORWARD;
        elapsed_r  <= '0;
        pause_el_r <= '0;
        held_r     <= '0;
      end
      if (state_r == ST_UPDATE) begin
        phase_r    <= ph_new;
        elapsed_r  <= e_new;
        pause_el_r <= p_new;
        held_r     <= held_new;
      end
      // Take the rounded angle off the last partial product.
      if (state_r == ST_MUL_ANG && ang_last) begin
        held_r <= mang_nxt[ANGLE_W+F2_W-2:F2_W-1];
      end
    end
  end

  // Serial datapath; payload only, no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      mstep_r <= {{GAIN_W{1'b0}}, in_data.delta_time};
    end else if (state_r == ST_MUL_STEP) begin
      mstep_r <= mstep_nxt;
    end

    if (state_r == ST_UPDATE) begin
      idx_r    <= idx_new;
      upper_r  <= u[TFB-1];
      invert_r <= invert_new;
    end

    // Preload the rounding half so it lands at bit 16 of the product.
    if (state_r == ST_ROM) begin
      mang_r <= {ROUND_HALF, f2};
    end else if (state_r == ST_MUL_ANG) begin
      mang_r <= mang_nxt;
    end

    if (accept || state_r == ST_ROM) begin
      cnt_r <= '0;
    end else if (state_r == ST_MUL_STEP || state_r == ST_MUL_ANG) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Output register: hold the result until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.angle      <= held_r;
      out_data_r.phase_code <= phase_r;
      out_data_r.finished   <= (phase_r == PH_DONE);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/rcsp_checker.sv
module rcsp_checker
  import rcsp_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input sweep_in_t  in_data,
  input logic       out_valid,
  input logic       out_ready,
  input sweep_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in work");

  a_finished_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.finished == (out_data.phase_code == PH_DONE))
    else $error("finished flag disagrees with phase");

  a_done_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.phase_code == PH_DONE |-> out_data.angle == '0)
    else $error("done phase with nonzero angle");

endmodule

bind raised_cosine_sweep_profile_core rcsp_checker u_rcsp_checker (.*);

FILE: tb/sweep_profile_checker.sv
`timescale 1ns / 1ps

module sweep_profile_checker
  import rcsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  sweep_in_t             in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  sweep_out_t            out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    sweeps_done,
  output int                    peaks_held
);

  localparam int          DEPTH = COS_TABLE_DEPTH_DEF;
  localparam int          TFB   = TIME_FRACTION_BITS_DEF;
  localparam logic [63:0] T_ONE = 64'd1 << TFB;
  localparam logic [63:0] T_SAT = (T_ONE << 2) - 64'd1;

  logic [16:0]        cos_q16 [0:DEPTH];
  logic [ANGLE_W-1:0] peak_angle;
  logic [PAUSE_W-1:0] hold_len;
  logic [GAIN_W-1:0]  gain;
  logic [17:0]        t_run;
  logic [PAUSE_W-1:0] t_hold;
  phase_t             sweep_ph;
  logic [ANGLE_W-1:0] angle_now;
  sweep_out_t         predicted_pos [$];

  initial fail_count  = 0;
  initial pending     = 0;
  initial sweeps_done = 0;
  initial peaks_held  = 0;

  // Quarter-wave cosine in Q16, Taylor series evaluated in Q30.
  initial begin : build_cos
    logic [63:0] x, x2, term, sum;
    for (int k = 0; k <= DEPTH; k++) begin
      x    = (64'(k) * HALF_PI_Q30) / 64'(DEPTH);
      x2   = (x * x) >> 30;
      term = Q30_ONE;
      sum  = Q30_ONE;
      for (int n = 1; n <= 9; n++) begin
        term = ((term * x2) >> 30) / (64'(2 * n - 1) * 64'(2 * n));
        if (n % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      if (sum > (64'd1 << 62)) sum = '0;
      else if (sum > Q30_ONE) sum = Q30_ONE;
      cos_q16[k] = 17'((sum + (64'd1 << 13)) >> 14);
    end
  end

  // Twice the rise factor in Q16 (the rise factor in Q17), for u in [0, 1.0).
  function automatic logic [63:0] rise_x2(logic [63:0] u);
    logic [63:0] half, v, idx;
    half = T_ONE >> 1;
    v    = (u < half) ? u : (T_ONE - u);
    idx  = (v * 64'(2 * DEPTH) + half) >> TFB;
    if (idx > 64'(DEPTH)) idx = 64'(DEPTH);
    if (u < half) return 64'(F2_ONE) - 64'(cos_q16[idx]);
    return 64'(F2_ONE) + 64'(cos_q16[idx]);
  endfunction

  function automatic logic [ANGLE_W-1:0] scale_to_peak(logic [63:0] f2);
    return ANGLE_W'((f2 * 64'(peak_angle) + 64'(ROUND_HALF)) >> (F2_W - 1));
  endfunction

  function automatic sweep_out_t step_sweep(sweep_in_t req);
    logic [63:0] step, run, held;
    logic        holding;
    if (req.restart) begin
      t_run     = '0;
      t_hold    = '0;
      sweep_ph  = PH_FORWARD;
      angle_now = '0;
    end else if (sweep_ph != PH_DONE) begin
      step    = (64'(req.delta_time) * 64'(gain)) >> GAIN_FRAC;
      run     = 64'(t_run);
      holding = 1'b0;
      if (sweep_ph == PH_PAUSED) begin
        held = 64'(t_hold) + step;
        if (held > 64'(PAUSE_MAX)) held = 64'(PAUSE_MAX);
        if (held >= 64'(hold_len)) begin
          // pause over: drop the overshoot, resume from the peak with this tick
          t_hold   = '0;
          sweep_ph = PH_BACKWARD;
          run      = T_ONE;
        end else begin
          t_hold    = PAUSE_W'(held);
          angle_now = peak_angle;
          holding   = 1'b1;
        end
      end
      if (!holding) begin
        run = run + step;
        if (run > T_SAT) run = T_SAT;
        if (sweep_ph == PH_FORWARD) begin
          if (run >= T_ONE) begin
            run = T_ONE;
            if (hold_len != '0) begin
              sweep_ph  = PH_PAUSED;
              angle_now = peak_angle;
              holding   = 1'b1;
              peaks_held++;
            end else begin
              sweep_ph = PH_BACKWARD;
            end
          end else begin
            angle_now = scale_to_peak(rise_x2(run));
          end
        end
        if (!holding && sweep_ph == PH_BACKWARD) begin
          if (run >= 2 * T_ONE) begin
            run       = 2 * T_ONE;
            angle_now = '0;
            sweep_ph  = PH_DONE;
            sweeps_done++;
          end else begin
            angle_now = scale_to_peak(64'(F2_TWO) - rise_x2(run - T_ONE));
          end
        end
        t_run = 18'(run);
      end
    end
    return '{angle: angle_now, phase_code: sweep_ph, finished: (sweep_ph == PH_DONE)};
  endfunction

  always @(posedge clk) begin : watch
    sweep_out_t want;
    if (!rst_n) begin
      peak_angle = MAX_ANGLE_RST;
      hold_len   = PAUSE_RST;
      gain       = GAIN_RST;
      t_run      = '0;
      t_hold     = '0;
      sweep_ph   = PH_FORWARD;
      angle_now  = '0;
      predicted_pos.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_ANGLE:      peak_angle = cfg_data[ANGLE_W-1:0];
          CFG_PAUSE_DURATION: hold_len   = cfg_data[PAUSE_W-1:0];
          CFG_SPEED_GAIN:     gain       = cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predicted_pos.push_back(step_sweep(in_data));
      if (out_valid && out_ready) begin
        if (predicted_pos.size() == 0) begin
          $error("result with no request pending: angle %0d phase %0d",
                 out_data.angle, out_data.phase_code);
          fail_count++;
        end else begin
          want = predicted_pos.pop_front();
          if (out_data.angle !== want.angle) begin
            $error("angle: expected %0d, got %0d", want.angle, out_data.angle);
            fail_count++;
          end
          if (out_data.phase_code !== want.phase_code) begin
            $error("phase_code: expected %0d, got %0d", want.phase_code, out_data.phase_code);
            fail_count++;
          end
          if (out_data.finished !== want.finished) begin
            $error("finished: expected %0d, got %0d", want.finished, out_data.finished);
            fail_count++;
          end
        end
      end
    end
    pending = predicted_pos.size();
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb
  import rcsp_pkg::*;
;

  // Index with no register behind it; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int PEAK_MAX   = 92160;
  localparam int IDLE_LIMIT = 3000;
  localparam int N_PHASES   = 10;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  sweep_in_t             in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  sweep_out_t            out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int fail_count, pending, sweeps_done, peaks_held;

  // Stimulus bookkeeping; gain_now only sizes the ticks, it predicts nothing.
  logic [GAIN_W-1:0] gain_now   = GAIN_RST;
  int                n_ticks    = 0;
  int                n_restarts = 0;
  int                n_writes   = 0;
  int                n_settings = 0;
  int                burst_left = 0;
  int                idle_cycles = 0;

  always #6 clk = ~clk;

  raised_cosine_sweep_profile_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sweep_profile_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .sweeps_done (sweeps_done),
    .peaks_held  (peaks_held)
  );

  // Receiver back-pressure: switch at random between always ready, coin-flip ready,
  // and long runs of ready / stalled.
  int   ready_mode  = 0;
  int   mode_left   = 0;
  int   run_left    = 0;
  logic ready_level = 1'b1;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(100, 400);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: begin
        if (run_left == 0) begin
          run_left    = $urandom_range(1, 25);
          ready_level = ~ready_level;
        end else begin
          run_left--;
        end
        out_ready <= ready_level;
      end
    endcase
  end

  // Watchdog: end the run if no channel moves a request for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one tick request and hold it until accepted. Bursts of random
  // length are separated by random gaps; a quarter of the bursts start at once.
  task automatic send_tick(logic [DELTA_W-1:0] delta, logic restart);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= '{delta_time: delta, restart: restart};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    n_ticks++;
    if (restart) n_restarts++;
  endtask

  // Drop valid and hold off until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Register write; only called with the block idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    if (idx == CFG_SPEED_GAIN) gain_now = GAIN_W'(value);
    n_writes++;
  endtask

  function automatic int unsigned pick_hold_len();
    case ($urandom_range(0, 5))
      0, 1:    return 0;
      2, 3:    return $urandom_range(1, 200000);
      4:       return $urandom_range(0, 24'hFFFFFF);
      default: return 24'hFFFFFF;
    endcase
  endfunction

  function automatic int unsigned pick_gain();
    case ($urandom_range(0, 3))
      0, 1:    return $urandom_range(1, 512);
      2:       return $urandom_range(0, 65535);
      default: return ($urandom_range(0, 1) != 0) ? 65535 : 0;
    endcase
  endfunction

  // Size a tick so a half sweep takes roughly ticks_per_half requests at the
  // current gain; some ticks are instead uniform or at the extremes.
  function automatic logic [DELTA_W-1:0] pick_delta(int unsigned ticks_per_half);
    logic [63:0] aim;
    int unsigned lo, hi;
    case ($urandom_range(0, 9))
      0, 1: return DELTA_W'($urandom_range(0, 65535));
      2:    return ($urandom_range(0, 1) != 0) ? 16'hFFFF : DELTA_W'($urandom_range(0, 15));
      default: begin
        if (gain_now == '0) aim = 64'd65535;
        else aim = (64'd1 << 24) / (64'(gain_now) * 64'(ticks_per_half));
        if (aim > 64'd65535) aim = 64'd65535;
        lo = 32'(aim / 2);
        hi = 32'(aim + aim / 2);
        if (hi > 65535) hi = 65535;
        return DELTA_W'($urandom_range(hi, lo));
      end
    endcase
  endfunction

  // Rewrite one register (or the spare index) between requests.
  task automatic poke_register();
    case ($urandom_range(0, 3))
      0:       write_reg(CFG_MAX_ANGLE, $urandom_range(0, PEAK_MAX));
      1:       write_reg(CFG_PAUSE_DURATION, pick_hold_len());
      2:       write_reg(CFG_SPEED_GAIN, pick_gain());
      default: write_reg(CFG_SPARE, $urandom_range(0, 24'hFFFFFF));
    endcase
  endtask

  initial begin
    int base, len, ticks;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset defaults: cross the half point exactly, land the rise exactly on
    // 1.0 with no pause (turn back in the same tick), finish, tick while done.
    n_settings++;
    send_tick(16'hFFFF, 1'b1);
    send_tick(16'd0, 1'b0);
    send_tick(16'd16384, 1'b0);
    send_tick(16'd16384, 1'b0);
    send_tick(16'd16383, 1'b0);
    send_tick(16'd16385, 1'b0);
    send_tick(16'd32768, 1'b0);
    send_tick(16'hFFFF, 1'b0);
    send_tick(16'hFFFF, 1'b0);
    send_tick(16'd0, 1'b1);
    drain();

    // Full peak, short pause, top gain: overshoot into the pause, end the
    // pause with overshoot dropped, then saturate the timer into done.
    n_settings++;
    write_reg(CFG_MAX_ANGLE, PEAK_MAX);
    write_reg(CFG_PAUSE_DURATION, 300);
    write_reg(CFG_SPEED_GAIN, 65535);
    send_tick(16'd1, 1'b0);
    send_tick(16'd300, 1'b0);
    send_tick(16'd1, 1'b0);
    send_tick(16'd1, 1'b0);
    send_tick(16'hFFFF, 1'b0);
    drain();

    // Longest pause: change the peak mid-pause, then saturate the pause timer.
    n_settings++;
    write_reg(CFG_MAX_ANGLE, 1);
    write_reg(CFG_PAUSE_DURATION, 24'hFFFFFF);
    write_reg(CFG_SPARE, 24'hFFFFFF);
    send_tick(16'd0, 1'b1);
    send_tick(16'hFFFF, 1'b0);
    send_tick(16'hFFFF, 1'b0);
    drain();
    write_reg(CFG_MAX_ANGLE, 0);
    send_tick(16'd0, 1'b0);
    send_tick(16'hFFFF, 1'b0);
    drain();

    // Cut the pause to zero while paused: the next tick ends it at once.
    write_reg(CFG_MAX_ANGLE, 46080);
    send_tick(16'd0, 1'b1);
    send_tick(16'hFFFF, 1'b0);
    drain();
    write_reg(CFG_PAUSE_DURATION, 0);
    send_tick(16'd0, 1'b0);
    drain();

    // Random sweeps over several settings; each setting change waits for
    // the block to go idle, which also exercises the sender holding off.
    for (int p = 0; p < N_PHASES; p++) begin
      n_settings++;
      case (p)
        0: begin
          write_reg(CFG_MAX_ANGLE, PEAK_MAX);
          write_reg(CFG_PAUSE_DURATION, 0);
          write_reg(CFG_SPEED_GAIN, 256);
        end
        1: begin
          write_reg(CFG_MAX_ANGLE, 0);
          write_reg(CFG_PAUSE_DURATION, 24'hFFFFFF);
          write_reg(CFG_SPEED_GAIN, 65535);
        end
        2: begin
          write_reg(CFG_SPEED_GAIN, 0);
          write_reg(CFG_MAX_ANGLE, PEAK_MAX);
          write_reg(CFG_PAUSE_DURATION, 1);
        end
        3: begin
          write_reg(CFG_SPEED_GAIN, 1);
          write_reg(CFG_MAX_ANGLE, $urandom_range(0, PEAK_MAX));
          write_reg(CFG_PAUSE_DURATION, pick_hold_len());
        end
        default: begin
          write_reg(CFG_MAX_ANGLE, $urandom_range(0, PEAK_MAX));
          write_reg(CFG_PAUSE_DURATION, pick_hold_len());
          write_reg(CFG_SPEED_GAIN, pick_gain());
        end
      endcase
      base = n_ticks;
      while (n_ticks - base < ((p == 2) ? 30 : 120)) begin
        send_tick(DELTA_W'($urandom), 1'b1);
        len   = $urandom_range(2, 24);
        ticks = $urandom_range(len, 3 * len + 6);
        for (int i = 0; i < ticks && n_ticks - base < 120; i++) begin
          // mostly well-formed sweeps, with the odd restart breaking one off
          if ($urandom_range(0, 24) == 0) send_tick(DELTA_W'($urandom), 1'b1);
          else send_tick(pick_delta(len), 1'b0);
          if ($urandom_range(0, 49) == 0) begin
            drain();
            poke_register();
          end
        end
      end
      drain();
    end

    // Let any straggling result surface before the verdict.
    repeat (40) @(posedge clk);
    $display("Ran %0d tick requests (%0d restarts) with %0d register writes over %0d settings;",
             n_ticks, n_restarts, n_writes, n_settings);
    $display("%0d sweeps reached the end and %0d holds at the peak were entered.",
             sweeps_done, peaks_held);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rcsp_pkg.sv
rtl/raised_cosine_sweep_profile_core.sv
rtl/rcsp_checker.sv
tb/sweep_profile_checker.sv
tb/tb.sv
